// File: hw/rtl/vss_pkg.sv
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types and constants for the voice steal selector: the voice entry
// record and the scan token that travels along the row of cells.
// ----------------------------------------------------------------------------
package vss_pkg;

  // field widths of the item and of one entry
  localparam int MASK_W  = 8;
  localparam int SRC_W   = 8;
  localparam int LEVEL_W = 16;
  localparam int VIDX_W  = 4;
  localparam int COUNT_W = 5;

  // channels that count as sounding
  localparam int CHANNELS = 8;
  localparam logic [MASK_W-1:0] LIVE_MASK =
    (CHANNELS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << CHANNELS) - 1);

  // item function codes
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // register byte address selector (bit 2 of paddr picks the word)
  localparam logic REG_VOICES_IN_USE = 1'b0;
  localparam logic [COUNT_W-1:0] VOICES_IN_USE_RESET = COUNT_W'(16);

  // one voice entry
  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [SRC_W-1:0]   src;
    logic [LEVEL_W-1:0] level;
  } vss_entry_t;

  // scan token handed from cell to cell; the candidate index travels beside it
  typedef struct packed {
    logic               valid;
    logic               done;   // silent voice found, later cells pass it on
    logic               have;   // a candidate is held
    logic               mine;   // candidate belongs to the requester
    logic [SRC_W-1:0]   src;    // requesting source
    logic [LEVEL_W-1:0] level;  // candidate level
  } vss_tok_t;

endpackage

// File: hw/rtl/vss_in_if.sv
// ----------------------------------------------------------------------------
// vss_in_if
// Input channel of the voice steal selector: valid/ready with one item word.
// ----------------------------------------------------------------------------
interface vss_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [vss_pkg::VIDX_W-1:0]  voice_index;
  logic [vss_pkg::SRC_W-1:0]   source_id;
  logic [vss_pkg::MASK_W-1:0]  channel_mask;
  logic [vss_pkg::LEVEL_W-1:0] level;

  modport source (output valid, func, voice_index, source_id, channel_mask, level,
                  input ready);
  modport sink   (input valid, func, voice_index, source_id, channel_mask, level,
                  output ready);
endinterface

// File: hw/rtl/vss_out_if.sv
// ----------------------------------------------------------------------------
// vss_out_if
// Result channel of the voice steal selector: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface vss_out_if;
  logic                       valid;
  logic                       ready;
  logic [vss_pkg::VIDX_W-1:0] chosen_voice;
  logic                       voice_found;

  modport source (output valid, chosen_voice, voice_found, input ready);
  modport sink   (input valid, chosen_voice, voice_found, output ready);
endinterface

// File: hw/rtl/vss_cell.sv
// ----------------------------------------------------------------------------
// vss_cell
// One voice entry plus one stage of the scan: compares the passing token with
// its own entry, updates the candidate and hands the token to the next cell.
// ----------------------------------------------------------------------------
module vss_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  vss_pkg::vss_entry_t wr_entry,
  input  logic                active,
  input  logic                advance,
  input  vss_pkg::vss_tok_t   tok_in,
  input  logic [IDX_W-1:0]    idx_in,
  output vss_pkg::vss_tok_t   tok_out,
  output logic [IDX_W-1:0]    idx_out
);

  vss_pkg::vss_entry_t entry_r;
  vss_pkg::vss_tok_t   tok_r, tok_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                silent;
  logic                mine;

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (wr_en) begin
      entry_r <= wr_entry;
    end
  end

  // candidate update
  always_comb begin
    silent  = (entry_r.mask & vss_pkg::LIVE_MASK) == '0;
    mine    = entry_r.src == tok_in.src;
    tok_nxt = tok_in;
    idx_nxt = idx_in;
    if (tok_in.valid && active && !tok_in.done) begin
      if (silent) begin
        idx_nxt      = IDX_W'(CELL_IDX);
        tok_nxt.have = 1'b1;
        tok_nxt.done = 1'b1;
      end else if (!tok_in.have) begin
        idx_nxt       = IDX_W'(CELL_IDX);
        tok_nxt.have  = 1'b1;
        tok_nxt.mine  = mine;
        tok_nxt.level = entry_r.level;
      end else if ((!tok_in.mine && mine) ||
                   ((!tok_in.mine || mine) && (entry_r.level < tok_in.level))) begin
        idx_nxt       = IDX_W'(CELL_IDX);
        tok_nxt.mine  = mine;
        tok_nxt.level = entry_r.level;
      end
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (advance) begin
      tok_r <= tok_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

// File: hw/rtl/voice_steal_selector.sv
// ----------------------------------------------------------------------------
// voice_steal_selector
// Picks the voice to steal from a table of voice entries held in a row of
// cells, one entry per cell.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one word per item. func = write stores channel_mask,
//   source_id and level into entry voice_index (indexes beyond the table
//   are dropped) and gives no result. func = request sends a scan token
//   down the cell row, one cell per cycle while the row is not held; the
//   chosen voice is loaded into the output register once the token leaves
//   the last cell and comes out on out_chan. One request is in the row at
//   a time: in_chan.ready stays low while the token travels. Writes are
//   taken every cycle while no scan runs.
//   The result sits in an output register; a new item is accepted while it
//   waits. If the receiver stalls and a second result reaches the end of the
//   row, the row holds its token until the output register frees.
//   voices_in_use (APB, address 0) limits the scan to the first entries.
//   Reset empties the row, marks all voices silent with source and level
//   zero and sets voices_in_use to 16.
// ----------------------------------------------------------------------------
module voice_steal_selector #(
  parameter int VOICES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  vss_in_if.sink                        in_chan,
  vss_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [vss_pkg::COUNT_W-1:0]  voices_in_use_r;
  logic                         busy_r, busy_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [vss_pkg::VIDX_W-1:0]   out_voice_r;
  logic                         out_found_r;
  logic                         in_fire;
  logic                         wr_fire;
  logic                         req_fire;
  logic                         advance;
  logic                         out_load;
  vss_pkg::vss_entry_t          wr_entry;
  vss_pkg::vss_tok_t            tok [0:VOICES];
  logic [IDX_W-1:0]             idx [0:VOICES];

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voices_in_use_r <= vss_pkg::VOICES_IN_USE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == vss_pkg::REG_VOICES_IN_USE)) begin
      voices_in_use_r <= pwdata[vss_pkg::COUNT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == vss_pkg::REG_VOICES_IN_USE) ?
                  32'(voices_in_use_r) : 32'd0;

  // input handshake
  assign in_chan.ready = !busy_r;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign wr_fire  = in_fire && (in_chan.func == vss_pkg::FUNC_WRITE);
  assign req_fire = in_fire && (in_chan.func == vss_pkg::FUNC_REQUEST);

  assign wr_entry.mask  = in_chan.channel_mask;
  assign wr_entry.src   = in_chan.source_id;
  assign wr_entry.level = in_chan.level;

  // token entering the first cell
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = req_fire;
    tok[0].src   = in_chan.source_id;
    idx[0]       = '0;
  end

  // row holds only when a finished token meets a full, stalled output
  assign advance  = !(tok[VOICES].valid && out_valid_r && !out_chan.ready);
  assign out_load = tok[VOICES].valid && advance;

  // cell row
  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    logic active;
    logic wr_hit;
    assign active = 32'(voices_in_use_r) > 32'(g);
    assign wr_hit = wr_fire && (32'(in_chan.voice_index) == 32'(g));
    vss_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_hit),
      .wr_entry (wr_entry),
      .active   (active),
      .advance  (advance),
      .tok_in   (tok[g]),
      .idx_in   (idx[g]),
      .tok_out  (tok[g+1]),
      .idx_out  (idx[g+1])
    );
  end

  // busy tracking and output register control
  always_comb begin
    busy_nxt = busy_r;
    if (req_fire) begin
      busy_nxt = 1'b1;
    end else if (out_load) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_voice_r <= tok[VOICES].have ? vss_pkg::VIDX_W'(idx[VOICES]) : '0;
      out_found_r <= tok[VOICES].have;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.chosen_voice = out_voice_r;
  assign out_chan.voice_found  = out_found_r;

  // no finished token at the end of the row while the input side is open
  a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !tok[VOICES].valid)
    else $error("token in cell row while not busy");

  // an accepted request closes the input side
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_fire |=> busy_r)
    else $error("request accepted without entering busy");

  // a new result only comes from the end of the row
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tok[VOICES].valid))
    else $error("result appeared without a finished token");

  // no voice found reports index zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_voice_r == '0))
    else $error("nonzero voice with no voice found");

endmodule
